[hdl/peu_pkg.sv]
// Package for the particle Euler update core: status codes, register indexes,
// fixed-point constants and the 32-bit saturation helper. No dependencies.
`timescale 1ns / 1ps

package peu_pkg;

  typedef enum logic [1:0] {
    ST_INACTIVE = 2'd0,
    ST_EXPIRED  = 2'd1,
    ST_ALIVE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_FRAME_STEP = 2'd0,
    REG_CAMERA_X   = 2'd1,
    REG_CAMERA_Y   = 2'd2,
    REG_CAMERA_Z   = 2'd3
  } reg_idx_e;

  localparam int unsigned STEP_W = 17;
  localparam int unsigned ADDR_W = 4;

  localparam logic [STEP_W-1:0] FRAME_STEP_RST = 17'd1092;

  // half of gravity in Q16.16 (magnitude of -4.905)
  localparam logic [18:0] HALF_G_MAG = 19'd321454;

  localparam logic signed [32:0] LIFE_TWO   = 33'sd131072;
  localparam logic signed [32:0] LIFE_THREE = 33'sd196608;
  localparam logic signed [32:0] LIFE_FOUR  = 33'sd262144;

  localparam logic signed [40:0] BLUE_MUL  = 41'sd75;
  localparam logic signed [40:0] BLUE_OFS  = 41'sd14745600;
  localparam logic signed [40:0] GREEN_MUL = 41'sd95;
  localparam logic signed [40:0] GREEN_OFS = 41'sd8192000;

  localparam logic signed [50:0] DIST_EXPIRED = -51'sd65536;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (x < -40'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/peu_if.sv]
// Stream interfaces of the particle Euler update core: particle record in,
// updated record out. Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface peu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] life_in;
  logic signed [31:0] pos_x_in;
  logic signed [31:0] pos_y_in;
  logic signed [31:0] pos_z_in;
  logic signed [31:0] vel_x_in;
  logic signed [31:0] vel_y_in;
  logic signed [31:0] vel_z_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;

  modport source (output valid, life_in, pos_x_in, pos_y_in, pos_z_in,
                  vel_x_in, vel_y_in, vel_z_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, life_in, pos_x_in, pos_y_in, pos_z_in,
                vel_x_in, vel_y_in, vel_z_in, green_in, blue_in,
                output ready);
endinterface

interface peu_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] life_out;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic signed [31:0] pos_z_out;
  logic signed [31:0] vel_x_out;
  logic signed [31:0] vel_y_out;
  logic signed [31:0] vel_z_out;
  logic [7:0]         green_out;
  logic [7:0]         blue_out;
  logic signed [50:0] cam_dist_sq;

  modport source (output valid, status, life_out, pos_x_out, pos_y_out, pos_z_out,
                  vel_x_out, vel_y_out, vel_z_out, green_out, blue_out, cam_dist_sq,
                  input ready);
  modport sink (input valid, status, life_out, pos_x_out, pos_y_out, pos_z_out,
                vel_x_out, vel_y_out, vel_z_out, green_out, blue_out, cam_dist_sq,
                output ready);
endinterface

[hdl/particle_euler_update_core.sv]
// Particle Euler update core: five-stage pipeline with APB register file.
// Depends on peu_pkg and the stream interfaces in peu_if.sv.
//
//   channel   dir  handshake        contents
//   in_i      in   valid/ready      life, position, velocity, green, blue
//   out_o     out  valid/ready      status, life, position, velocity, colors, dist
//   apb       in   psel/penable     frame_step, camera_x/y/z (byte addr 4*i)
//
// One transfer per cycle in and out while out_o is not stalled; five register
// stages lie between the input port and out_o. Stage 1 decrements life, applies
// gravity and the color ramps, stage 2 forms velocity times frame step, stage 3
// updates position and forms the camera offsets, stage 4 squares the camera
// offsets, stage 5 sums them into the output register.
// Each stage holds its item while the next one is full and stalled; a bubble frees it.
// rst_ni clears all valid bits and restores the register reset values.
`timescale 1ns / 1ps

module particle_euler_update_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  peu_in_if.sink                     in_i,
  peu_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [peu_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import peu_pkg::*;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] life;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [7:0]         green;
    logic [7:0]         blue;
  } rec_t;

  typedef struct packed {
    logic signed [49:0] mx;
    logic signed [49:0] my;
    logic signed [49:0] mz;
  } prod_t;

  typedef struct packed {
    logic [32:0] ax;
    logic [32:0] ay;
    logic [32:0] az;
  } mag_t;

  typedef struct packed {
    logic [49:0] qx;
    logic [49:0] qy;
    logic [49:0] qz;
  } sq_t;

  // register file
  logic [STEP_W-1:0]  frame_step_q;
  logic signed [20:0] grav_q;
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic               wr_en;
  reg_idx_e           wr_idx;
  logic [35:0]        grav_mag;
  logic signed [36:0] grav_neg;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign wr_idx   = reg_idx_e'(paddr[3:2]);
  assign grav_mag = 36'(HALF_G_MAG) * 36'(pwdata[STEP_W-1:0]);
  assign grav_neg = -$signed({1'b0, grav_mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_step_q <= FRAME_STEP_RST;
      grav_q       <= -21'sd5357;
      cam_x_q      <= '0;
      cam_y_q      <= '0;
      cam_z_q      <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_FRAME_STEP: begin
          frame_step_q <= pwdata[STEP_W-1:0];
          grav_q       <= 21'(grav_neg >>> 16);
        end
        REG_CAMERA_X: cam_x_q <= pwdata;
        REG_CAMERA_Y: cam_y_q <= pwdata;
        REG_CAMERA_Z: cam_z_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_FRAME_STEP: prdata = {15'd0, frame_step_q};
      REG_CAMERA_X:   prdata = cam_x_q;
      REG_CAMERA_Y:   prdata = cam_y_q;
      REG_CAMERA_Z:   prdata = cam_z_q;
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  logic [4:0] vld_q;
  logic [5:0] adv;

  always_comb begin
    adv[5] = out_o.ready;
    for (int k = 4; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: life, gravity, color ramps
  logic signed [32:0] life_new;
  logic signed [37:0] vy_sum;
  logic signed [40:0] blue_t, green_t;
  logic               in_active, in_alive;
  rec_t               s1_d, s1_q;

  assign life_new  = 33'(in_i.life_in) - $signed({16'd0, frame_step_q});
  assign in_active = in_i.life_in > 32'sd0;
  assign in_alive  = in_active && (life_new > 33'sd0);
  assign vy_sum    = 38'(in_i.vel_y_in) + 38'(grav_q);
  assign blue_t    = 41'(life_new) * BLUE_MUL - BLUE_OFS;
  assign green_t   = 41'(life_new) * GREEN_MUL - GREEN_OFS;

  always_comb begin
    s1_d.status = ST_INACTIVE;
    s1_d.life   = in_i.life_in;
    s1_d.px     = in_i.pos_x_in;
    s1_d.py     = in_i.pos_y_in;
    s1_d.pz     = in_i.pos_z_in;
    s1_d.vx     = in_i.vel_x_in;
    s1_d.vy     = in_i.vel_y_in;
    s1_d.vz     = in_i.vel_z_in;
    s1_d.green  = in_i.green_in;
    s1_d.blue   = in_i.blue_in;
    if (in_active) begin
      s1_d.status = ST_EXPIRED;
      s1_d.life   = life_new[31:0];
    end
    if (in_alive) begin
      s1_d.status = ST_ALIVE;
      s1_d.vy     = sat32(40'(vy_sum));
      if (life_new >= LIFE_THREE) s1_d.blue = blue_t[23:16];
      if (life_new >= LIFE_TWO && life_new <= LIFE_FOUR) s1_d.green = green_t[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
  end

  // stage 2: velocity times frame step
  rec_t               s2_q;
  prod_t              p2_q;
  logic signed [49:0] step_s;

  assign step_s = $signed({33'd0, frame_step_q});

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_q     <= s1_q;
      p2_q.mx  <= 50'(s1_q.vx) * step_s;
      p2_q.my  <= 50'(s1_q.vy) * step_s;
      p2_q.mz  <= 50'(s1_q.vz) * step_s;
    end
  end

  // stage 3: position update and camera offsets
  rec_t               s3_d, s3_q;
  mag_t               m3_d, m3_q;
  logic signed [31:0] nx, ny, nz;
  logic signed [32:0] dx, dy, dz;

  assign nx = sat32(40'(s2_q.px) + 40'(p2_q.mx >>> 16));
  assign ny = sat32(40'(s2_q.py) + 40'(p2_q.my >>> 16));
  assign nz = sat32(40'(s2_q.pz) + 40'(p2_q.mz >>> 16));
  assign dx = 33'(nx) - 33'(cam_x_q);
  assign dy = 33'(ny) - 33'(cam_y_q);
  assign dz = 33'(nz) - 33'(cam_z_q);

  always_comb begin
    s3_d = s2_q;
    if (s2_q.status == ST_ALIVE) begin
      s3_d.px = nx;
      s3_d.py = ny;
      s3_d.pz = nz;
    end
    m3_d.ax = dx[32] ? 33'(-dx) : 33'(dx);
    m3_d.ay = dy[32] ? 33'(-dy) : 33'(dy);
    m3_d.az = dz[32] ? 33'(-dz) : 33'(dz);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_q <= s3_d;
      m3_q <= m3_d;
    end
  end

  // stage 4: squares
  rec_t        s4_q;
  sq_t         q4_q;
  logic [65:0] sqx, sqy, sqz;

  assign sqx = 66'(m3_q.ax) * 66'(m3_q.ax);
  assign sqy = 66'(m3_q.ay) * 66'(m3_q.ay);
  assign sqz = 66'(m3_q.az) * 66'(m3_q.az);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_q    <= s3_q;
      q4_q.qx <= sqx[65:16];
      q4_q.qy <= sqy[65:16];
      q4_q.qz <= sqz[65:16];
    end
  end

  // stage 5: distance sum into the output register
  rec_t               s5_q;
  logic signed [50:0] dist_d, dist_q;

  assign dist_d = (s4_q.status == ST_ALIVE)
                ? $signed(51'(q4_q.qx) + 51'(q4_q.qy) + 51'(q4_q.qz))
                : DIST_EXPIRED;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s5_q   <= s4_q;
      dist_q <= dist_d;
    end
  end

  assign out_o.valid       = vld_q[4];
  assign out_o.status      = s5_q.status;
  assign out_o.life_out    = s5_q.life;
  assign out_o.pos_x_out   = s5_q.px;
  assign out_o.pos_y_out   = s5_q.py;
  assign out_o.pos_z_out   = s5_q.pz;
  assign out_o.vel_x_out   = s5_q.vx;
  assign out_o.vel_y_out   = s5_q.vy;
  assign out_o.vel_z_out   = s5_q.vz;
  assign out_o.green_out   = s5_q.green;
  assign out_o.blue_out    = s5_q.blue;
  assign out_o.cam_dist_sq = dist_q;

endmodule

[hdl/peu_chk.sv]
// Port-level checker for the particle Euler update core, bound to the top.
// Depends on peu_pkg for status codes and the expired distance value.
`timescale 1ns / 1ps

module peu_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] life_i,
  input logic [50:0] dist_i
);
  import peu_pkg::*;

  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(dist_i))
    else $error("stalled output transfer changed");

  a_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_ALIVE |-> !life_i[31] && life_i != 32'd0 && !dist_i[50])
    else $error("alive particle with non-positive life or negative distance");

  a_dead_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_INACTIVE || status_i == ST_EXPIRED)
      |-> dist_i == DIST_EXPIRED)
    else $error("inactive or expired particle without expired distance");

  a_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EXPIRED |-> life_i[31] || life_i == 32'd0)
    else $error("expired particle with positive life");

endmodule

bind particle_euler_update_core peu_chk u_peu_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .life_i      (out_o.life_out),
  .dist_i      (out_o.cam_dist_sq)
);

[tb/particle_euler_update_core_tb.sv]
// Self-checking testbench for particle_euler_update_core: directed table plus random
// particle records on valid/ready streams, APB register phases, random stalls.
// Depends on peu_pkg and the stream interfaces in peu_if.sv.
`timescale 1ns / 1ps

module particle_euler_update_core_tb;
  import peu_pkg::*;

  localparam int     ItemsPerPhase = 119;
  localparam int     NumPhases     = 8;
  localparam int     QuietLimit    = 4000;
  localparam int     SettleCycles  = 12;
  localparam longint OneSec        = 65536;
  localparam longint HalfGrav      = 321454;

  localparam logic signed [31:0] MaxQ = 32'sh7fff_ffff;
  localparam logic signed [31:0] MinQ = 32'sh8000_0000;
  localparam logic signed [50:0] DistNone = -51'sd65536;

  typedef struct {
    logic signed [31:0] life;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] vx, vy, vz;
    logic [7:0]         green, blue;
  } particle_t;

  typedef struct {
    status_e            status;
    logic signed [31:0] life;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] vx, vy, vz;
    logic [7:0]         green, blue;
    logic signed [50:0] dist_sq;
  } update_t;

  typedef struct {
    particle_t p;
    bit        typed;
    update_t   want;
  } vector_t;

  localparam update_t NoWant = '{ST_INACTIVE, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00, 0};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  peu_in_if  in_bus ();
  peu_out_if out_bus ();

  particle_euler_update_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [16:0]        step_q;
  logic signed [31:0] cam_x, cam_y, cam_z;

  update_t   pending_q[$];
  vector_t   directed_q[$];
  int        mismatches;
  int        sent_count, checked_count;
  int        n_alive, n_expired, n_inactive;
  int        quiet_cycles;
  int        tx_burst;
  int        rx_hold, rx_free;

  logic signed [31:0] ramp_lives[9] = '{32'sd197700, 32'sd197699, 32'sd132164, 32'sd132163,
                                        32'sd263236, 32'sd263237, 32'sd328772, 32'sd656452,
                                        32'sd1093};

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t result %0d: %s", $time, checked_count, msg);
  endtask

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return MaxQ;
    if (x < -64'sd2147483648) return MinQ;
    return x[31:0];
  endfunction

  function automatic bit [63:0] cam_sq(logic signed [31:0] p, logic signed [31:0] c);
    longint    df;
    bit [63:0] m;
    df = longint'(p) - longint'(c);
    m  = (df < 0) ? -df : df;
    return (m * m) >> 16;
  endfunction

  function automatic update_t euler_update(particle_t p);
    update_t   r;
    longint    fs, nl;
    bit [63:0] dsum;
    fs = step_q;
    r  = '{ST_INACTIVE, p.life, p.px, p.py, p.pz, p.vx, p.vy, p.vz, p.green, p.blue, DistNone};
    if (p.life > 0) begin
      nl     = longint'(p.life) - fs;
      r.life = nl[31:0];
      if (nl > 0) begin
        r.status = ST_ALIVE;
        r.vy = clamp32(longint'(p.vy) + ((-HalfGrav * fs) >>> 16));
        r.px = clamp32(longint'(p.px) + ((longint'(p.vx) * fs) >>> 16));
        r.py = clamp32(longint'(p.py) + ((longint'(r.vy) * fs) >>> 16));
        r.pz = clamp32(longint'(p.pz) + ((longint'(p.vz) * fs) >>> 16));
        dsum = cam_sq(r.px, cam_x) + cam_sq(r.py, cam_y) + cam_sq(r.pz, cam_z);
        r.dist_sq = dsum[50:0];
        if (nl >= 3 * OneSec) r.blue = 8'((75 * nl - 64'sd14745600) >>> 16);
        if (nl >= 2 * OneSec && nl <= 4 * OneSec) r.green = 8'((95 * nl - 64'sd8192000) >>> 16);
      end else begin
        r.status = ST_EXPIRED;
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? MaxQ : MinQ;
    if (r <= 3) return $urandom;
    return int'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    int        k;
    k = $urandom_range(0, 99);
    if (k < 15) begin
      case ($urandom_range(0, 3))
        0: p.life = 0;
        1: p.life = MinQ;
        2: p.life = -int'($urandom_range(1, 1 << 20));
        default: p.life = $urandom | 32'h8000_0000;
      endcase
    end else if (k < 27) begin
      p.life = $urandom_range(1, step_q + 1);
    end else if (k < 82) begin
      p.life = step_q + $urandom_range(0, 7 * 65536);
    end else begin
      p.life = $urandom;
    end
    p.px = pick_coord();
    p.py = pick_coord();
    p.pz = pick_coord();
    p.vx = pick_coord();
    p.vy = pick_coord();
    p.vz = pick_coord();
    p.green = 8'($urandom_range(0, 255));
    p.blue  = 8'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic int idle_gap();
    int r;
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    if (r < 98) return $urandom_range(20, 60);
    tx_burst = $urandom_range(40, 120);
    return 0;
  endfunction

  task automatic send_particle(particle_t p, bit typed, update_t want);
    int      gap;
    update_t expd;
    gap = idle_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.life_in  <= p.life;
    in_bus.pos_x_in <= p.px;
    in_bus.pos_y_in <= p.py;
    in_bus.pos_z_in <= p.pz;
    in_bus.vel_x_in <= p.vx;
    in_bus.vel_y_in <= p.vy;
    in_bus.vel_z_in <= p.vz;
    in_bus.green_in <= p.green;
    in_bus.blue_in  <= p.blue;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    expd = typed ? want : euler_update(p);
    pending_q.push_back(expd);
    sent_count++;
    case (expd.status)
      ST_ALIVE:   n_alive++;
      ST_EXPIRED: n_expired++;
      default:    n_inactive++;
    endcase
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [16:0] fs, logic signed [31:0] cx, logic signed [31:0] cy,
                              logic signed [31:0] cz);
    logic [31:0] vals[4];
    reg_idx_e    ri;
    vals[REG_FRAME_STEP] = {15'd0, fs};
    vals[REG_CAMERA_X]   = cx;
    vals[REG_CAMERA_Y]   = cy;
    vals[REG_CAMERA_Z]   = cz;
    ri = REG_FRAME_STEP;
    repeat (4) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {ri, 2'b00};
      pwdata  <= vals[ri];
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      ri = ri.next();
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    step_q = fs;
    cam_x  = cx;
    cam_y  = cy;
    cam_z  = cz;
  endtask

  task automatic load_directed();
    particle_t p;
    // inactive and expired records with known results
    p = '{32'sd0, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, 8'hff, 8'hff};
    directed_q.push_back('{p, 1'b1,
      '{ST_INACTIVE, 32'sd0, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, 8'hff, 8'hff, DistNone}});
    p = '{MinQ, MinQ, MinQ, MinQ, MinQ, MinQ, MinQ, 8'h00, 8'h00};
    directed_q.push_back('{p, 1'b1,
      '{ST_INACTIVE, MinQ, MinQ, MinQ, MinQ, MinQ, MinQ, MinQ, 8'h00, 8'h00, DistNone}});
    p = '{-32'sd1, 32'sh1234_5678, -32'sd77, 32'sd0, 32'sd9, MinQ, MaxQ, 8'h5a, 8'ha5};
    directed_q.push_back('{p, 1'b1,
      '{ST_INACTIVE, -32'sd1, 32'sh1234_5678, -32'sd77, 32'sd0, 32'sd9, MinQ, MaxQ,
        8'h5a, 8'ha5, DistNone}});
    p = '{32'sd1092, MaxQ, MinQ, 32'sd0, MinQ, MaxQ, 32'sd1, 8'h80, 8'h7f};
    directed_q.push_back('{p, 1'b1,
      '{ST_EXPIRED, 32'sd0, MaxQ, MinQ, 32'sd0, MinQ, MaxQ, 32'sd1, 8'h80, 8'h7f, DistNone}});
    p = '{32'sd1, 32'sd5, 32'sd6, 32'sd7, 32'sd8, 32'sd9, 32'sd10, 8'h01, 8'hfe};
    directed_q.push_back('{p, 1'b1,
      '{ST_EXPIRED, -32'sd1091, 32'sd5, 32'sd6, 32'sd7, 32'sd8, 32'sd9, 32'sd10,
        8'h01, 8'hfe, DistNone}});
    // alive records: saturation, ramp edges, blue wrap
    p = '{32'sd1093, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00};
    directed_q.push_back('{p, 1'b0, NoWant});
    p = '{MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, MaxQ, 8'hff, 8'hff};
    directed_q.push_back('{p, 1'b0, NoWant});
    p = '{MaxQ, MinQ, MinQ, MinQ, MinQ, MinQ, MinQ, 8'h00, 8'h00};
    directed_q.push_back('{p, 1'b0, NoWant});
    p = '{32'sd100000, 32'sd1000, MinQ, -32'sd1000, 32'sd65536, MinQ, -32'sd65536, 8'h10, 8'h20};
    directed_q.push_back('{p, 1'b0, NoWant});
    foreach (ramp_lives[i]) begin
      p = '{ramp_lives[i], 32'sh0001_8000, -32'sh0003_0000, 32'sh0010_0000,
            32'sh0002_0000, 32'sh0005_0000, -32'sh0001_0000, 8'h33, 8'hcc};
      directed_q.push_back('{p, 1'b0, NoWant});
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      out_bus.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_bus.ready <= 1'b0;
    end else if (rx_free > 0) begin
      rx_free--;
      out_bus.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:39]: begin
          rx_free = $urandom_range(1, 8);
          out_bus.ready <= 1'b1;
        end
        [40:84]: begin
          rx_hold = $urandom_range(0, 2);
          out_bus.ready <= 1'b0;
        end
        [85:96]: begin
          rx_hold = $urandom_range(3, 11);
          out_bus.ready <= 1'b0;
        end
        [97:98]: begin
          rx_hold = $urandom_range(19, 59);
          out_bus.ready <= 1'b0;
        end
        default: begin
          rx_free = $urandom_range(50, 200);
          out_bus.ready <= 1'b1;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    update_t got, want;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got = '{status_e'(out_bus.status), out_bus.life_out, out_bus.pos_x_out,
              out_bus.pos_y_out, out_bus.pos_z_out, out_bus.vel_x_out, out_bus.vel_y_out,
              out_bus.vel_z_out, out_bus.green_out, out_bus.blue_out, out_bus.cam_dist_sq};
      if (pending_q.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.life !== want.life)
          report_mismatch($sformatf("life_out %0d, expected %0d", got.life, want.life));
        if (got.px !== want.px)
          report_mismatch($sformatf("pos_x_out %0d, expected %0d", got.px, want.px));
        if (got.py !== want.py)
          report_mismatch($sformatf("pos_y_out %0d, expected %0d", got.py, want.py));
        if (got.pz !== want.pz)
          report_mismatch($sformatf("pos_z_out %0d, expected %0d", got.pz, want.pz));
        if (got.vx !== want.vx)
          report_mismatch($sformatf("vel_x_out %0d, expected %0d", got.vx, want.vx));
        if (got.vy !== want.vy)
          report_mismatch($sformatf("vel_y_out %0d, expected %0d", got.vy, want.vy));
        if (got.vz !== want.vz)
          report_mismatch($sformatf("vel_z_out %0d, expected %0d", got.vz, want.vz));
        if (got.green !== want.green)
          report_mismatch($sformatf("green_out %0d, expected %0d", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue_out %0d, expected %0d", got.blue, want.blue));
        if (got.dist_sq !== want.dist_sq)
          report_mismatch($sformatf("cam_dist_sq %0d, expected %0d", got.dist_sq,
                                    want.dist_sq));
      end
      checked_count++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
        (psel === 1'b1 && penable === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("transfer watchdog expired with %0d results outstanding", pending_q.size());
    $display("particle_euler_update_core regression: fail");
    $finish;
  end

  initial begin
    logic [16:0]        fs;
    logic signed [31:0] cx, cy, cz;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_bus.valid    <= 1'b0;
    in_bus.life_in  <= '0;
    in_bus.pos_x_in <= '0;
    in_bus.pos_y_in <= '0;
    in_bus.pos_z_in <= '0;
    in_bus.vel_x_in <= '0;
    in_bus.vel_y_in <= '0;
    in_bus.vel_z_in <= '0;
    in_bus.green_in <= '0;
    in_bus.blue_in  <= '0;
    step_q = FRAME_STEP_RST;
    cam_x  = '0;
    cam_y  = '0;
    cam_z  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_directed();
    foreach (directed_q[i]) send_particle(directed_q[i].p, directed_q[i].typed, directed_q[i].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph)
        0: begin
          fs = 17'd0;
          cx = MaxQ;
          cy = MinQ;
          cz = '0;
        end
        1: begin
          fs = 17'd65536;
          cx = MinQ;
          cy = MaxQ;
          cz = MaxQ;
        end
        default: begin
          if (ph == 2) fs = 17'd1092;
          else if ($urandom_range(0, 1)) fs = 17'($urandom_range(0, 65536));
          else fs = 17'($urandom_range(500, 4000));
          cx = pick_coord();
          cy = pick_coord();
          cz = pick_coord();
        end
      endcase
      program_regs(fs, cx, cy, cz);
      repeat (ItemsPerPhase) send_particle(rand_particle(), 1'b0, NoWant);
    end

    drain_results();
    $display("covered %0d records over %0d register settings: %0d alive, %0d expired, %0d inactive",
             sent_count, NumPhases + 1, n_alive, n_expired, n_inactive);
    $display("checked %0d results, %0d mismatches", checked_count, mismatches);
    if (mismatches == 0) begin
      $display("particle_euler_update_core regression: pass");
    end else begin
      $display("particle_euler_update_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/peu_pkg.sv
hdl/peu_if.sv
hdl/particle_euler_update_core.sv
hdl/peu_chk.sv
tb/particle_euler_update_core_tb.sv
